/* rtl/core/ciau_pkg.sv */
package ciau_pkg;

    localparam int DATA_W = 64;
    localparam int ACT_W  = 3;
    localparam int ST_W   = 2;
    localparam int CNT_W  = $clog2(DATA_W);
    localparam int EXP_W  = $clog2(DATA_W);
    localparam int BIT_W  = $clog2(EXP_W);

    localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
    localparam logic [ACT_W-1:0] ACT_POW = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [ST_W-1:0] ST_DIVZERO  = 2'd2;
    localparam logic [ST_W-1:0] ST_ZEROPOW  = 2'd3;

    localparam logic [DATA_W-1:0] POS_LIMIT = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] NEG_LIMIT = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic start;
        logic div;
    } md_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md_rsp_t;

endpackage

/* rtl/core/ciau_muldiv.sv */
module ciau_muldiv
    import ciau_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  md_req_t           req,
    input  logic [DATA_W-1:0] x,
    input  logic [DATA_W-1:0] y,
    output md_rsp_t           rsp,
    output logic [DATA_W-1:0] hi,
    output logic [DATA_W-1:0] lo
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              div_reg, div_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] hi_reg, hi_next;
    logic [DATA_W-1:0] lo_reg, lo_next;
    logic [DATA_W-1:0] y_reg, y_next;

    logic [DATA_W:0]   op_a;
    logic [DATA_W:0]   op_b;
    logic [DATA_W+1:0] sum;
    logic              qbit;
    logic              last;

    // One bit per cycle: a shift-add step for multiply, a restoring
    // subtract step for divide, both on the same adder.
    always_comb
    begin
        op_a = div_reg ? {hi_reg, lo_reg[DATA_W-1]} : {1'b0, hi_reg};
        if (div_reg)
        begin
            op_b = ~{1'b0, y_reg};
        end
        else if (lo_reg[0])
        begin
            op_b = {1'b0, y_reg};
        end
        else
        begin
            op_b = '0;
        end
        sum  = {1'b0, op_a} + {1'b0, op_b} + {{(DATA_W+1){1'b0}}, div_reg};
        qbit = sum[DATA_W+1];
        last = (cnt_reg == CNT_W'(DATA_W-1));
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        y_next    = y_reg;
        if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (div_reg)
            begin
                hi_next = qbit ? sum[DATA_W-1:0] : op_a[DATA_W-1:0];
                lo_next = {lo_reg[DATA_W-2:0], qbit};
            end
            else
            begin
                hi_next = sum[DATA_W:1];
                lo_next = {sum[0], lo_reg[DATA_W-1:1]};
            end
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            div_next  = req.div;
            cnt_next  = '0;
            hi_next   = '0;
            lo_next   = x;
            y_next    = y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        cnt_reg <= cnt_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        y_reg   <= y_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign hi       = hi_reg;
    assign lo       = lo_reg;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("operation started while the unit is busy");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && last) |=> (done_reg && !busy_reg))
        else $error("done does not follow the last iteration");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done raised while the unit is still busy");
`endif

endmodule

/* rtl/core/checked_int64_arith_unit.sv */
// Checked signed 64-bit arithmetic unit: add, subtract, multiply, truncating
// divide and integer power, each with an exact overflow check and a status code.
// Add, subtract, unused codes and the trivial power cases are settled in the
// decode state and go to the finish state. Multiply and divide wait on the shared
// radix-2 unit that handles one bit of the multiplier or quotient per cycle.
// Power runs square-and-multiply over the six low exponent bits on that same
// unit, at most 11 multiplies. One beat is processed at a time; a finished
// result waits in the output register while the next beat is accepted.
module checked_int64_arith_unit
    import ciau_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ACT_W-1:0]         action,
    input  logic signed [DATA_W-1:0] operand_a,
    input  logic signed [DATA_W-1:0] operand_b,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] value,
    output logic [ST_W-1:0]          status
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_DECODE = 8'b00000010,
        S_MDW    = 8'b00000100,
        S_PSQ    = 8'b00001000,
        S_PSQW   = 8'b00010000,
        S_PML    = 8'b00100000,
        S_PMLW   = 8'b01000000,
        S_FIN    = 8'b10000000
    } state_t;

    state_t            state_reg, state_next;
    logic [ACT_W-1:0]  act_reg;
    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    logic              neg_reg, neg_next;
    logic              is_div_reg, is_div_next;
    logic [DATA_W-1:0] limit_reg, limit_next;
    logic [DATA_W-1:0] base_reg, base_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [DATA_W-1:0] res_val_reg, res_val_next;
    logic [ST_W-1:0]   res_st_reg, res_st_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] value_reg;
    logic [ST_W-1:0]   status_reg;

    md_req_t           md_req;
    md_rsp_t           md_rsp;
    logic [DATA_W-1:0] md_x;
    logic [DATA_W-1:0] md_y;
    logic [DATA_W-1:0] md_hi;
    logic [DATA_W-1:0] md_lo;

    logic              in_accept;
    logic              out_load;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W-1:0] add_r;
    logic [DATA_W-1:0] sub_r;
    logic              sgn;
    logic              md_ovf;
    logic [EXP_W-1:0]  exp_bits;

    function automatic logic [DATA_W-1:0] apply_sign(input logic [DATA_W-1:0] mag,
                                                     input logic neg);
        return neg ? (DATA_W'(0) - mag) : mag;
    endfunction

    ciau_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .x     (md_x),
        .y     (md_y),
        .rsp   (md_rsp),
        .hi    (md_hi),
        .lo    (md_lo)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        mag_a    = a_reg[DATA_W-1] ? (DATA_W'(0) - a_reg) : a_reg;
        mag_b    = b_reg[DATA_W-1] ? (DATA_W'(0) - b_reg) : b_reg;
        sgn      = a_reg[DATA_W-1] ^ b_reg[DATA_W-1];
        add_r    = a_reg + b_reg;
        sub_r    = a_reg - b_reg;
        md_ovf   = ((!is_div_reg) && (md_hi != '0)) || (md_lo > limit_reg);
        exp_bits = b_reg[EXP_W-1:0];
    end

    always_comb
    begin
        state_next   = state_reg;
        neg_next     = neg_reg;
        is_div_next  = is_div_reg;
        limit_next   = limit_reg;
        base_next    = base_reg;
        acc_next     = acc_reg;
        bit_next     = bit_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        md_req.start = 1'b0;
        md_req.div   = 1'b0;
        md_x         = acc_reg;
        md_y         = acc_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_val_next = '0;
                res_st_next  = ST_OK;
                neg_next     = sgn;
                limit_next   = sgn ? NEG_LIMIT : POS_LIMIT;
                is_div_next  = 1'b0;
                state_next   = S_FIN;
                case (act_reg)
                    ACT_ADD:
                    begin
                        if (((a_reg ^ add_r) & (b_reg ^ add_r)) >> (DATA_W-1) != '0)
                        begin
                            res_st_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            res_val_next = add_r;
                        end
                    end
                    ACT_SUB:
                    begin
                        if (((a_reg ^ b_reg) & (a_reg ^ sub_r)) >> (DATA_W-1) != '0)
                        begin
                            res_st_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            res_val_next = sub_r;
                        end
                    end
                    ACT_MUL:
                    begin
                        md_req.start = 1'b1;
                        md_x         = mag_a;
                        md_y         = mag_b;
                        state_next   = S_MDW;
                    end
                    ACT_DIV:
                    begin
                        if (b_reg == '0)
                        begin
                            res_st_next = ST_DIVZERO;
                        end
                        else
                        begin
                            md_req.start = 1'b1;
                            md_req.div   = 1'b1;
                            md_x         = mag_a;
                            md_y         = mag_b;
                            is_div_next  = 1'b1;
                            state_next   = S_MDW;
                        end
                    end
                    ACT_POW:
                    begin
                        if ((a_reg == '0) && (b_reg == '0))
                        begin
                            res_val_next = DATA_W'(1);
                            res_st_next  = ST_ZEROPOW;
                        end
                        else if (b_reg[DATA_W-1] || (a_reg == '0))
                        begin
                            res_val_next = '0;
                        end
                        else if (a_reg == DATA_W'(1))
                        begin
                            res_val_next = DATA_W'(1);
                        end
                        else if (a_reg == '1)
                        begin
                            res_val_next = b_reg[0] ? a_reg : DATA_W'(1);
                        end
                        else if (b_reg[DATA_W-1:EXP_W] != '0)
                        begin
                            res_val_next = DATA_W'(1);
                            res_st_next  = ST_OVERFLOW;
                        end
                        else
                        begin
                            neg_next   = a_reg[DATA_W-1] & b_reg[0];
                            limit_next = (a_reg[DATA_W-1] & b_reg[0]) ? NEG_LIMIT
                                                                      : POS_LIMIT;
                            base_next  = mag_a;
                            acc_next   = DATA_W'(1);
                            bit_next   = BIT_W'(EXP_W-1);
                            state_next = S_PSQ;
                        end
                    end
                    default:
                    begin
                        res_val_next = '0;
                    end
                endcase
            end
            S_MDW:
            begin
                if (md_rsp.done)
                begin
                    state_next = S_FIN;
                    if (md_ovf)
                    begin
                        res_val_next = '0;
                        res_st_next  = ST_OVERFLOW;
                    end
                    else
                    begin
                        res_val_next = apply_sign(md_lo, neg_reg);
                        res_st_next  = ST_OK;
                    end
                end
            end
            S_PSQ:
            begin
                if (acc_reg == DATA_W'(1))
                begin
                    state_next = S_PML;
                end
                else
                begin
                    md_req.start = 1'b1;
                    state_next   = S_PSQW;
                end
            end
            S_PSQW:
            begin
                if (md_rsp.done)
                begin
                    if (md_ovf)
                    begin
                        res_val_next = DATA_W'(1);
                        res_st_next  = ST_OVERFLOW;
                        state_next   = S_FIN;
                    end
                    else
                    begin
                        acc_next   = md_lo;
                        state_next = S_PML;
                    end
                end
            end
            S_PML:
            begin
                if (exp_bits[bit_reg])
                begin
                    md_req.start = 1'b1;
                    md_y         = base_reg;
                    state_next   = S_PMLW;
                end
                else if (bit_reg == '0)
                begin
                    res_val_next = apply_sign(acc_reg, neg_reg);
                    res_st_next  = ST_OK;
                    state_next   = S_FIN;
                end
                else
                begin
                    bit_next   = bit_reg - BIT_W'(1);
                    state_next = S_PSQ;
                end
            end
            S_PMLW:
            begin
                if (md_rsp.done)
                begin
                    acc_next = md_lo;
                    if (md_ovf)
                    begin
                        res_val_next = DATA_W'(1);
                        res_st_next  = ST_OVERFLOW;
                        state_next   = S_FIN;
                    end
                    else if (bit_reg == '0)
                    begin
                        res_val_next = apply_sign(md_lo, neg_reg);
                        res_st_next  = ST_OK;
                        state_next   = S_FIN;
                    end
                    else
                    begin
                        bit_next   = bit_reg - BIT_W'(1);
                        state_next = S_PSQ;
                    end
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg <= action;
            a_reg   <= operand_a;
            b_reg   <= operand_b;
        end
        if (out_load)
        begin
            value_reg  <= res_val_reg;
            status_reg <= res_st_reg;
        end
        neg_reg     <= neg_next;
        is_div_reg  <= is_div_next;
        limit_reg   <= limit_next;
        base_reg    <= base_next;
        acc_reg     <= acc_next;
        bit_reg     <= bit_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_DECODE))
        else $error("accepted beat is not decoded in the next cycle");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> ((state_reg == S_MDW) || (state_reg == S_PSQW)
                         || (state_reg == S_PMLW)))
        else $error("shared unit finished outside a wait state");

    a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !md_rsp.busy)
        else $error("shared unit busy while no beat is in work");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid && (state_reg == S_IDLE)))
        else $error("finished result not presented");
`endif

endmodule
